// ===== rtl/core/wsp_pkg.sv =====
`timescale 1ns / 1ps

package wsp_pkg;

    localparam int HANDLE_W    = 32;
    localparam int IN_WEIGHT_W = 16;
    localparam int RND_W       = 32;
    localparam int SLOT_W      = 4;
    localparam int LEFT_W      = 5;
    localparam int ACTION_W    = 2;

    // slave tdata: handle, weight, random word
    localparam int S_TDATA_W   = 80;
    // master tdata: handle, slot, left count, zero pad to 48
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - HANDLE_W - SLOT_W - LEFT_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_PULL    = 2'd2,
        ACT_RESTORE = 2'd3
    } t_action;

    typedef struct packed {
        logic clear;
        logic append;
        logic restore;
        logic pull_start;
        logic div_step;
        logic walk_start;
        logic sel_latch;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic any_avail;
        logic div_last;
        logic walk_done;
    } t_status;

endpackage

// ===== rtl/core/wsp_ctrl.sv =====
`timescale 1ns / 1ps

module wsp_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic [wsp_pkg::ACTION_W-1:0]  i_action,
    output logic                          o_s_tready,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    input  wsp_pkg::t_status              i_status,
    output wsp_pkg::t_cmd                 o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK,
        ST_READ,
        ST_DONE
    } t_state;

    t_state           r_state;
    logic             r_s_ready;
    logic             r_m_valid;
    logic             accept;
    logic             out_free;
    wsp_pkg::t_action action;

    assign accept   = i_s_tvalid && r_s_ready;
    assign out_free = !r_m_valid || i_m_tready;
    assign action   = wsp_pkg::t_action'(i_action);

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (action)
                        wsp_pkg::ACT_CLEAR:   o_cmd.clear      = 1'b1;
                        wsp_pkg::ACT_APPEND:  o_cmd.append     = 1'b1;
                        wsp_pkg::ACT_RESTORE: o_cmd.restore    = 1'b1;
                        wsp_pkg::ACT_PULL:    o_cmd.pull_start = 1'b1;
                        default:              o_cmd.clear      = 1'b0;
                    endcase
                end
            end
            ST_DIV: begin
                o_cmd.div_step   = 1'b1;
                o_cmd.walk_start = i_status.div_last;
            end
            ST_WALK: begin
                o_cmd.sel_latch = i_status.walk_done;
            end
            ST_DONE: begin
                o_cmd.load_out = out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_s_ready <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            // a new result replaces the one being taken in the same cycle
            if (o_cmd.load_out) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept && action == wsp_pkg::ACT_PULL) begin
                        r_s_ready <= 1'b0;
                        // empty list: report not found straight away
                        r_state   <= i_status.any_avail ? ST_DIV : ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (i_status.div_last) begin
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (i_status.walk_done) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_s_ready <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready = r_s_ready;
    assign o_m_tvalid = r_m_valid;

endmodule

// ===== rtl/core/wsp_datapath.sv =====
`timescale 1ns / 1ps

module wsp_datapath #(
    parameter int ENTRIES     = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wsp_pkg::t_cmd                    i_cmd,
    output wsp_pkg::t_status                 o_status,
    input  logic [wsp_pkg::HANDLE_W-1:0]     i_handle,
    input  logic [wsp_pkg::IN_WEIGHT_W-1:0]  i_weight,
    input  logic [wsp_pkg::RND_W-1:0]        i_rnd,
    output logic [wsp_pkg::HANDLE_W-1:0]     o_handle,
    output logic [wsp_pkg::SLOT_W-1:0]       o_slot,
    output logic                             o_found,
    output logic [wsp_pkg::LEFT_W-1:0]       o_left
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SUM_W  = WEIGHT_BITS + CNT_W;
    localparam int DIV_W  = SUM_W + 1;
    localparam int MEM_W  = wsp_pkg::HANDLE_W + WEIGHT_BITS;
    localparam int DCNT_W = $clog2(wsp_pkg::RND_W);

    // entry store: handle above weight
    logic [MEM_W-1:0]             r_mem [ENTRIES];
    logic [MEM_W-1:0]             r_rd_q;

    logic [ENTRIES-1:0]           r_mask;
    logic [CNT_W-1:0]             r_loaded;
    logic [CNT_W-1:0]             r_avail_cnt;
    logic [SUM_W-1:0]             r_rem_sum;
    logic [SUM_W-1:0]             r_load_sum;
    logic                         r_found;

    logic [wsp_pkg::RND_W-1:0]    r_q;
    logic [DIV_W-1:0]             r_rem;
    logic [DIV_W-1:0]             r_div_d;
    logic [DCNT_W-1:0]            r_div_cnt;

    logic [IDX_W-1:0]             r_idx;
    logic                         r_issue;
    logic                         r_ev_vld;
    logic [IDX_W-1:0]             r_ev_idx;
    logic [SUM_W-1:0]             r_run;
    logic                         r_picked;
    logic [IDX_W-1:0]             r_pick_idx;
    logic                         r_have_first;
    logic [IDX_W-1:0]             r_first_idx;
    logic                         r_have_nz;
    logic [IDX_W-1:0]             r_nz_idx;
    logic [IDX_W-1:0]             r_sel;

    logic [wsp_pkg::HANDLE_W-1:0] r_out_handle;
    logic [wsp_pkg::SLOT_W-1:0]   r_out_slot;
    logic                         r_out_found;
    logic [wsp_pkg::LEFT_W-1:0]   r_out_left;

    logic [WEIGHT_BITS-1:0]       w_in;
    logic [WEIGHT_BITS-1:0]       ev_w;
    logic [wsp_pkg::HANDLE_W-1:0] ev_handle;
    logic [SUM_W-1:0]             run_n;
    logic                         v_lt_s;
    logic                         ev_act;
    logic                         ev_hit;
    logic [DIV_W:0]               div_t;
    logic                         div_ge;
    logic [DIV_W-1:0]             n_rem;
    logic                         issue_last;
    logic [IDX_W-1:0]             chosen;
    logic [IDX_W-1:0]             rd_addr;
    logic                         append_ok;
    logic [IDX_W-1:0]             wr_idx;
    logic [ENTRIES-1:0]           n_restore_mask;

    assign w_in      = WEIGHT_BITS'(i_weight);
    assign ev_w      = r_rd_q[WEIGHT_BITS-1:0];
    assign ev_handle = r_rd_q[MEM_W-1:WEIGHT_BITS];
    assign run_n     = r_run + SUM_W'(ev_w);
    assign v_lt_s    = r_rem < DIV_W'(r_rem_sum);
    assign ev_act    = r_ev_vld && !r_picked && r_mask[r_ev_idx];
    assign ev_hit    = v_lt_s && (DIV_W'(run_n) > r_rem);

    // one restoring step of random_word mod (remaining + 1)
    assign div_t  = {r_rem, r_q[wsp_pkg::RND_W-1]};
    assign div_ge = div_t >= {1'b0, r_div_d};
    assign n_rem  = div_ge ? DIV_W'(div_t - {1'b0, r_div_d}) : DIV_W'(div_t);

    assign issue_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_loaded;
    assign chosen     = r_picked ? r_pick_idx : (r_have_nz ? r_nz_idx : r_first_idx);
    assign rd_addr    = r_issue ? r_idx : r_sel;
    assign append_ok  = r_loaded < CNT_W'(ENTRIES);
    assign wr_idx     = r_loaded[IDX_W-1:0];

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_restore_mask[i] = CNT_W'(i) < r_loaded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && append_ok) begin
            r_mem[wr_idx] <= {i_handle, w_in};
        end
        r_rd_q <= r_mem[rd_addr];
    end

    // list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_loaded    <= '0;
            r_avail_cnt <= '0;
            r_rem_sum   <= '0;
            r_load_sum  <= '0;
        end else if (i_cmd.clear) begin
            r_mask      <= '0;
            r_loaded    <= '0;
            r_avail_cnt <= '0;
            r_rem_sum   <= '0;
            r_load_sum  <= '0;
        end else if (i_cmd.append) begin
            if (append_ok) begin
                r_mask[wr_idx] <= 1'b1;
                r_loaded       <= r_loaded + CNT_W'(1);
                r_avail_cnt    <= r_avail_cnt + CNT_W'(1);
                r_rem_sum      <= r_rem_sum + SUM_W'(w_in);
                r_load_sum     <= r_load_sum + SUM_W'(w_in);
            end
        end else if (i_cmd.restore) begin
            r_mask      <= n_restore_mask;
            r_avail_cnt <= r_loaded;
            r_rem_sum   <= r_load_sum;
        end else if (i_cmd.load_out && r_found) begin
            r_mask[r_sel] <= 1'b0;
            r_avail_cnt   <= r_avail_cnt - CNT_W'(1);
            r_rem_sum     <= r_rem_sum - SUM_W'(ev_w);
        end
    end

    // walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_ev_vld <= 1'b0;
        end else if (i_cmd.walk_start) begin
            r_issue  <= 1'b1;
            r_ev_vld <= 1'b0;
        end else if (i_cmd.sel_latch) begin
            r_issue  <= 1'b0;
            r_ev_vld <= 1'b0;
        end else begin
            r_ev_vld <= r_issue;
            if (r_issue && issue_last) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pull_start) begin
            r_found   <= r_avail_cnt != '0;
            r_q       <= i_rnd;
            r_rem     <= '0;
            r_div_d   <= DIV_W'(r_rem_sum) + DIV_W'(1);
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_q       <= r_q << 1;
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end

        if (i_cmd.walk_start) begin
            r_idx        <= '0;
            r_run        <= '0;
            r_picked     <= 1'b0;
            r_have_first <= 1'b0;
            r_have_nz    <= 1'b0;
        end else begin
            if (r_issue) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            r_ev_idx <= r_idx;
            if (ev_act) begin
                r_run <= run_n;
                if (ev_hit) begin
                    r_picked   <= 1'b1;
                    r_pick_idx <= r_ev_idx;
                end
                if (!r_have_first) begin
                    r_have_first <= 1'b1;
                    r_first_idx  <= r_ev_idx;
                end
                if (ev_w != '0) begin
                    r_have_nz <= 1'b1;
                    r_nz_idx  <= r_ev_idx;
                end
            end
        end

        if (i_cmd.sel_latch) begin
            r_sel <= chosen;
        end

        if (i_cmd.load_out) begin
            r_out_found <= r_found;
            if (r_found) begin
                r_out_handle <= ev_handle;
                r_out_slot   <= wsp_pkg::SLOT_W'(r_sel);
                r_out_left   <= wsp_pkg::LEFT_W'(r_avail_cnt - CNT_W'(1));
            end else begin
                r_out_handle <= '0;
                r_out_slot   <= '0;
                r_out_left   <= '0;
            end
        end
    end

    assign o_status.any_avail = r_avail_cnt != '0;
    assign o_status.div_last  = r_div_cnt == DCNT_W'(wsp_pkg::RND_W - 1);
    assign o_status.walk_done = r_picked || (!r_issue && !r_ev_vld);

    assign o_handle = r_out_handle;
    assign o_slot   = r_out_slot;
    assign o_found  = r_out_found;
    assign o_left   = r_out_left;

endmodule

// ===== rtl/core/weighted_shuffle_picker_top.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | tdata (low bit up)                          | tuser
// s_axis   | in  | entry_handle 32, entry_weight 16, random 32 | action 2
// m_axis   | out | picked_handle 32, picked_slot 4,            | found 1
//          |     | left_after 5, zero pad 7                    |
// Clear, append and restore finish in the cycle they are accepted.
// A pull runs a 32-step restoring modulo, then a walk over the entry store
// at one read per cycle.
// A pull on an empty list skips the modulo and the walk and reports not found.
// Reset is synchronous, active low, and empties the list.
// A waiting result holds the pull path in its final state until taken.

module weighted_shuffle_picker_top #(
    parameter int ENTRIES     = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_handle, entry_weight, random_word
    input  logic [wsp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // action
    input  logic [wsp_pkg::ACTION_W-1:0]      s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // picked_handle, picked_slot, left_after, zero pad
    output logic [wsp_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // found
    output logic                              m_axis_tuser
);

    wsp_pkg::t_cmd                   cmd;
    wsp_pkg::t_status                status;
    logic [wsp_pkg::HANDLE_W-1:0]    picked_handle;
    logic [wsp_pkg::SLOT_W-1:0]      picked_slot;
    logic [wsp_pkg::LEFT_W-1:0]      left_after;
    logic                            found;

    wsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_action   (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wsp_datapath #(
        .ENTRIES     (ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_handle (s_axis_tdata[31:0]),
        .i_weight (s_axis_tdata[47:32]),
        .i_rnd    (s_axis_tdata[79:48]),
        .o_handle (picked_handle),
        .o_slot   (picked_slot),
        .o_found  (found),
        .o_left   (left_after)
    );

    assign m_axis_tdata = {{wsp_pkg::M_PAD_W{1'b0}}, left_after, picked_slot, picked_handle};
    assign m_axis_tuser = found;

endmodule

// ===== rtl/core/wsp_checker.sv =====
`timescale 1ns / 1ps

module wsp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [wsp_pkg::ACTION_W-1:0]  s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [wsp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a pull occupies the block
    a_pull_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == wsp_pkg::ACT_PULL
            |=> !s_axis_tready)
        else $error("ready after pull");

    // list edits finish at once
    a_edit_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != wsp_pkg::ACT_PULL
            |=> s_axis_tready)
        else $error("ready dropped after list edit");

    // not-found result carries zeros
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("not-found result has nonzero data");

endmodule

bind weighted_shuffle_picker_top wsp_checker u_wsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/pick_order_checker.sv =====
`timescale 1ns / 1ps

module pick_order_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // entry_handle, entry_weight, random_word
    input  logic [wsp_pkg::S_TDATA_W-1:0] i_s_tdata,
    // action
    input  logic [wsp_pkg::ACTION_W-1:0]  i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // picked_handle, picked_slot, left_after, zero pad
    input  logic [wsp_pkg::M_TDATA_W-1:0] i_m_tdata,
    // found
    input  logic                          i_m_tuser,
    output int                            o_mismatches,
    output int                            o_pending
);

    localparam int ENTRIES = 16;

    typedef struct {
        logic [wsp_pkg::HANDLE_W-1:0] handle;
        logic [wsp_pkg::SLOT_W-1:0]   slot;
        logic                         found;
        logic [wsp_pkg::LEFT_W-1:0]   left;
    } t_pick;

    logic [wsp_pkg::HANDLE_W-1:0]    slot_handle [ENTRIES];
    logic [wsp_pkg::IN_WEIGHT_W-1:0] slot_weight [ENTRIES];
    logic [ENTRIES-1:0]              avail;
    int                              n_loaded;
    longint unsigned                 remaining_sum;
    longint unsigned                 loaded_sum;
    t_pick                           expected_picks [$];
    int                              mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 200)
                $error("%s: expected %0h, actual %0h", fname, want, got);
        end
    endfunction

    // Apply one accepted transaction to the shadow list; a pull queues its pick.
    function automatic void predict_pick(wsp_pkg::t_action act,
                                         logic [wsp_pkg::HANDLE_W-1:0] handle,
                                         logic [wsp_pkg::IN_WEIGHT_W-1:0] weight,
                                         logic [wsp_pkg::RND_W-1:0] rnd);
        t_pick           p;
        longint unsigned v;
        longint unsigned run;
        int              pick;
        int              first;
        int              last_nz;
        p = '{handle: '0, slot: '0, found: 1'b0, left: '0};
        pick = -1;
        first = -1;
        last_nz = -1;
        run = 0;
        case (act)
            wsp_pkg::ACT_CLEAR: begin
                avail = '0;
                n_loaded = 0;
                remaining_sum = 0;
                loaded_sum = 0;
            end
            wsp_pkg::ACT_APPEND: begin
                if (n_loaded < ENTRIES) begin
                    slot_handle[n_loaded] = handle;
                    slot_weight[n_loaded] = weight;
                    avail[n_loaded] = 1'b1;
                    n_loaded++;
                    remaining_sum += weight;
                    loaded_sum += weight;
                end
            end
            wsp_pkg::ACT_RESTORE: begin
                for (int i = 0; i < ENTRIES; i++)
                    avail[i] = (i < n_loaded);
                remaining_sum = loaded_sum;
            end
            default: begin
                if (avail != '0) begin
                    v = longint'(rnd) % (remaining_sum + 1);
                    if (v < remaining_sum) begin
                        for (int i = 0; i < n_loaded; i++) begin
                            if (avail[i] && pick < 0) begin
                                run += slot_weight[i];
                                if (run > v)
                                    pick = i;
                            end
                        end
                    end
                    // value at the sum: last weighted entry, else first available
                    if (pick < 0) begin
                        for (int i = 0; i < n_loaded; i++) begin
                            if (avail[i]) begin
                                if (first < 0)
                                    first = i;
                                if (slot_weight[i] != 0)
                                    last_nz = i;
                            end
                        end
                        pick = (last_nz >= 0) ? last_nz : first;
                    end
                    avail[pick] = 1'b0;
                    remaining_sum -= slot_weight[pick];
                    p.handle = slot_handle[pick];
                    p.slot   = pick[wsp_pkg::SLOT_W-1:0];
                    p.found  = 1'b1;
                    p.left   = wsp_pkg::LEFT_W'($countones(avail));
                end
                expected_picks = {expected_picks, p};
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_pick want;
        if (!i_rst_n) begin
            avail = '0;
            n_loaded = 0;
            remaining_sum = 0;
            loaded_sum = 0;
            expected_picks.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                predict_pick(wsp_pkg::t_action'(i_s_tuser), i_s_tdata[31:0],
                             i_s_tdata[47:32], i_s_tdata[79:48]);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_picks.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 200)
                        $error("result with no pull pending: tdata %0h, found %0b",
                               i_m_tdata, i_m_tuser);
                end else begin
                    want = expected_picks.pop_front();
                    check_field("picked_handle", want.handle, i_m_tdata[31:0]);
                    check_field("picked_slot", 32'(want.slot), 32'(i_m_tdata[35:32]));
                    check_field("left_after", 32'(want.left), 32'(i_m_tdata[40:36]));
                    check_field("found", 32'(want.found), 32'(i_m_tuser));
                    check_field("pad", '0, 32'(i_m_tdata[wsp_pkg::M_TDATA_W-1:41]));
                end
            end
        end
        o_pending <= expected_picks.size();
    end

endmodule

// ===== tb/tb_weighted_shuffle_picker_top.sv =====
`timescale 1ns / 1ps

module tb_weighted_shuffle_picker_top;

    localparam int ITEMS   = 1600;
    localparam int ENTRIES = 16;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // entry_handle, entry_weight, random_word
    logic [wsp_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    // action
    logic [wsp_pkg::ACTION_W-1:0]  s_axis_tuser = wsp_pkg::ACT_CLEAR;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // picked_handle, picked_slot, left_after, zero pad
    logic [wsp_pkg::M_TDATA_W-1:0] m_axis_tdata;
    // found
    logic                          m_axis_tuser;

    int mismatches;
    int pending_picks;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_sent = 0;
    int stim_loaded = 0;

    always #6 i_clk = ~i_clk;

    weighted_shuffle_picker_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pick_order_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pending_picks)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Leave tvalid high after the transaction so back-to-back items need no gap.
    task automatic send_item(wsp_pkg::t_action act, logic [31:0] handle,
                             logic [15:0] weight, logic [31:0] rnd);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {rnd, weight, handle};
        do @(posedge i_clk); while (!s_axis_tready);
        // appends to a full list are ignored and do not count
        if (!(act == wsp_pkg::ACT_APPEND && stim_loaded >= ENTRIES))
            items_sent++;
        if (act == wsp_pkg::ACT_CLEAR)
            stim_loaded = 0;
        else if (act == wsp_pkg::ACT_APPEND && stim_loaded < ENTRIES)
            stim_loaded++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_picks != 0);
    endtask

    function automatic logic [15:0] draw_weight(int mode);
        case (mode)
            0:       return ($urandom_range(3) == 0) ? 16'($urandom_range(1, 2)) : 16'h0;
            1:       return 16'($urandom_range(0, 3));
            2:       return 16'($urandom);
            default: return ($urandom_range(1) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [31:0] draw_rnd();
        case ($urandom_range(9))
            6, 7:    return 32'($urandom_range(0, 20));
            8:       return 32'hFFFF_FFFF;
            9:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_directed();
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), $urandom);  // empty after reset
        send_item(wsp_pkg::ACT_RESTORE, $urandom, 16'($urandom), $urandom);
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), $urandom);
        send_item(wsp_pkg::ACT_APPEND, 32'h0, 16'h0, $urandom);
        send_item(wsp_pkg::ACT_APPEND, 32'hFFFF_FFFF, 16'hFFFF, $urandom);
        send_item(wsp_pkg::ACT_APPEND, $urandom, 16'd1, $urandom);
        send_item(wsp_pkg::ACT_APPEND, $urandom, 16'd2, $urandom);
        // skips zero-weight head
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), 32'h0);
        // value lands on the sum
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), 32'hFFFF_FFFF);
        // sum again
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), 32'd1);
        // only zero weight left
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), $urandom);
        // exhausted
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), $urandom);
        send_item(wsp_pkg::ACT_RESTORE, $urandom, 16'($urandom), $urandom);
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), $urandom);
        send_item(wsp_pkg::ACT_CLEAR, $urandom, 16'($urandom), $urandom);
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), $urandom);
        // all weights zero
        send_item(wsp_pkg::ACT_APPEND, $urandom, 16'h0, $urandom);
        send_item(wsp_pkg::ACT_APPEND, $urandom, 16'h0, $urandom);
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), $urandom);
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), $urandom);
        send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), $urandom);
    endtask

    task automatic run_playlist();
        int mode;
        int rounds;
        mode = $urandom_range(3);
        rounds = $urandom_range(1, 2);
        if ($urandom_range(3) != 0)
            send_item(wsp_pkg::ACT_CLEAR, $urandom, 16'($urandom), $urandom);
        repeat ($urandom_range(1, 18))
            send_item(wsp_pkg::ACT_APPEND, $urandom, draw_weight(mode), $urandom);
        repeat (rounds) begin
            repeat ($urandom_range(0, stim_loaded + 2))
                send_item(wsp_pkg::ACT_PULL, $urandom, 16'($urandom), draw_rnd());
            if ($urandom_range(2) == 0)
                send_item(wsp_pkg::ACT_RESTORE, $urandom, 16'($urandom), $urandom);
        end
        // stray traffic with arbitrary content
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 4))
                send_item(wsp_pkg::t_action'($urandom_range(3)), $urandom, 16'($urandom),
                          $urandom);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 20; rx_idle_pct = 81; end
                1:       begin tx_idle_pct = 81; rx_idle_pct = 20; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            if (phase == 0)
                run_directed();
            while (items_sent < (phase + 1) * ITEMS / 3)
                run_playlist();
            wait_drained();
        end
        repeat (80) @(posedge i_clk);
        if (mismatches == 0 && pending_picks == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
